FILE: design/windowed_good_bad_stability_score_defines.svh
// assertion macros used by the checker file
`ifndef WINDOWED_GOOD_BAD_STABILITY_SCORE_DEFINES_SVH
`define WINDOWED_GOOD_BAD_STABILITY_SCORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define WGBSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define WGBSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/wgbss_pkg.sv
// shared constants and types of the windowed stability score block
package wgbss_pkg;

   localparam int DEPTH       = 64;
   localparam int VALUE_BITS  = 16;
   localparam int PTR_BITS    = $clog2(DEPTH);
   localparam int COUNT_BITS  = $clog2(DEPTH + 1);
   localparam int SUM_BITS    = 22;
   localparam int STAMP_BITS  = 48;
   localparam int MEAS_BITS   = 16;
   localparam int WINDOW_BITS = 32;
   localparam int SCORE_BITS  = 16;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPIRY_ENABLE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LENGTH = 1'b1;

   localparam int ENTRY_BITS = STAMP_BITS + VALUE_BITS + 1;

   // arithmetic unit widths
   localparam int RAD_BITS   = 2 * SUM_BITS + 2;
   localparam int ROOT_BITS  = SUM_BITS + 1;
   localparam int REM_BITS   = ROOT_BITS + 3;
   localparam int PROD_BITS  = 2 * SUM_BITS;
   localparam int SQRT_STEPS = RAD_BITS / 2;
   localparam int DIV_STEPS  = SCORE_BITS;
   localparam int STEP_BITS  = $clog2(SQRT_STEPS);

   localparam logic [SCORE_BITS-1:0] ONE_Q15 = SCORE_BITS'(32768);

   typedef struct packed {
      logic                  is_bad;
      logic [VALUE_BITS-1:0] value;
      logic [STAMP_BITS-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic                start;
      logic [SUM_BITS-1:0] good;
      logic [SUM_BITS-1:0] bad;
   } arith_req_type;

   typedef struct packed {
      logic                  done;
      logic [SCORE_BITS-1:0] score;
   } arith_status_type;

endpackage

FILE: design/wgbss_if.sv
// valid/ready channels for measurement words and score words
interface wgbss_req_if;
   logic                              valid;
   logic                              ready;
   logic                              req_type;
   logic [wgbss_pkg::MEAS_BITS-1:0]   measure_value;
   logic [wgbss_pkg::STAMP_BITS-1:0]  stamp;

   modport source (output valid, req_type, measure_value, stamp, input ready);
   modport sink (input valid, req_type, measure_value, stamp, output ready);
endinterface

interface wgbss_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [wgbss_pkg::SCORE_BITS-1:0]  score;
   logic [wgbss_pkg::SUM_BITS-1:0]    good_total;
   logic [wgbss_pkg::SUM_BITS-1:0]    bad_total;
   logic                              overflowed;

   modport source (output valid, score, good_total, bad_total, overflowed, input ready);
   modport sink (input valid, score, good_total, bad_total, overflowed, output ready);
endinterface

FILE: design/wgbss_ram.sv
// generic single write port ram with registered read
module wgbss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/wgbss_arith.sv
// shared subtractor unit: squares, digit-by-digit square root, then long division
module wgbss_arith (
   input  logic                        clock,
   input  logic                        reset,
   input  wgbss_pkg::arith_req_type    arith_req,
   output wgbss_pkg::arith_status_type arith_status
);

   localparam logic [2:0] A_IDLE = 3'd0;
   localparam logic [2:0] A_SQ_G = 3'd1;
   localparam logic [2:0] A_SQ_B = 3'd2;
   localparam logic [2:0] A_SQRT = 3'd3;
   localparam logic [2:0] A_DIV  = 3'd4;
   localparam logic [2:0] A_DONE = 3'd5;

   logic [2:0]                           state_ff, state_in;
   logic [wgbss_pkg::SUM_BITS-1:0]       good_ff, good_in;
   logic [wgbss_pkg::SUM_BITS-1:0]       bad_ff, bad_in;
   logic [wgbss_pkg::SUM_BITS-1:0]       gap_ff, gap_in;
   logic [wgbss_pkg::RAD_BITS-1:0]       rad_ff, rad_in;
   logic [wgbss_pkg::ROOT_BITS-1:0]      root_ff, root_in;
   logic [wgbss_pkg::REM_BITS-1:0]       rem_ff, rem_in;
   logic [wgbss_pkg::SCORE_BITS-1:0]     dvd_ff, dvd_in;
   logic [wgbss_pkg::SCORE_BITS-1:0]     quo_ff, quo_in;
   logic [wgbss_pkg::STEP_BITS-1:0]      step_ff, step_in;
   logic [wgbss_pkg::SCORE_BITS-1:0]     score_ff, score_in;

   logic [wgbss_pkg::SUM_BITS-1:0]       mul_op;
   logic [wgbss_pkg::PROD_BITS-1:0]      product;
   logic [wgbss_pkg::REM_BITS-1:0]       op_a, op_b;
   logic [wgbss_pkg::REM_BITS:0]         diff;
   logic                                 ge;
   logic [wgbss_pkg::SCORE_BITS-1:0]     quo_next;

   assign mul_op  = (state_ff == A_SQ_G) ? good_ff : bad_ff;
   assign product = {{wgbss_pkg::SUM_BITS{1'b0}}, mul_op}
                  * {{wgbss_pkg::SUM_BITS{1'b0}}, mul_op};

   // one subtractor serves both the root digits and the quotient bits
   always_comb begin
      if (state_ff == A_DIV) begin
         op_a = {rem_ff[wgbss_pkg::REM_BITS-2:0], dvd_ff[wgbss_pkg::SCORE_BITS-1]};
         op_b = {{(wgbss_pkg::REM_BITS - wgbss_pkg::ROOT_BITS){1'b0}}, root_ff};
      end else begin
         op_a = {rem_ff[wgbss_pkg::REM_BITS-3:0], rad_ff[wgbss_pkg::RAD_BITS-1 -: 2]};
         op_b = {1'b0, root_ff, 2'b01};
      end
   end

   assign diff     = {1'b0, op_a} - {1'b0, op_b};
   assign ge       = ~diff[wgbss_pkg::REM_BITS];
   assign quo_next = {quo_ff[wgbss_pkg::SCORE_BITS-2:0], ge};

   always_comb begin
      state_in = state_ff;
      good_in  = good_ff;
      bad_in   = bad_ff;
      gap_in   = gap_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      score_in = score_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (arith_req.start) begin
               good_in = arith_req.good;
               bad_in  = arith_req.bad;
               gap_in  = arith_req.good - arith_req.bad;
               if (arith_req.good > arith_req.bad) begin
                  state_in = A_SQ_G;
               end else begin
                  score_in = '0;
                  state_in = A_DONE;
               end
            end
         end
         A_SQ_G: begin
            rad_in   = {2'b00, product};
            state_in = A_SQ_B;
         end
         A_SQ_B: begin
            rad_in   = rad_ff + {2'b00, product};
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = A_SQRT;
         end
         A_SQRT: begin
            rad_in  = {rad_ff[wgbss_pkg::RAD_BITS-3:0], 2'b00};
            root_in = {root_ff[wgbss_pkg::ROOT_BITS-2:0], ge};
            rem_in  = ge ? diff[wgbss_pkg::REM_BITS-1:0] : op_a;
            step_in = step_ff + 1'b1;
            if (step_ff == wgbss_pkg::STEP_BITS'(wgbss_pkg::SQRT_STEPS - 1)) begin
               // dividend is gap << 15: high part seeds the remainder
               rem_in  = {{(wgbss_pkg::REM_BITS - wgbss_pkg::SUM_BITS + 1){1'b0}},
                          gap_ff[wgbss_pkg::SUM_BITS-1:1]};
               dvd_in  = {gap_ff[0], {(wgbss_pkg::SCORE_BITS-1){1'b0}}};
               quo_in  = '0;
               step_in = '0;
               state_in = A_DIV;
            end
         end
         A_DIV: begin
            rem_in  = ge ? diff[wgbss_pkg::REM_BITS-1:0] : op_a;
            quo_in  = quo_next;
            dvd_in  = {dvd_ff[wgbss_pkg::SCORE_BITS-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == wgbss_pkg::STEP_BITS'(wgbss_pkg::DIV_STEPS - 1)) begin
               score_in = (quo_next > wgbss_pkg::ONE_Q15) ? wgbss_pkg::ONE_Q15 : quo_next;
               state_in = A_DONE;
            end
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      good_ff  <= good_in;
      bad_ff   <= bad_in;
      gap_ff   <= gap_in;
      rad_ff   <= rad_in;
      root_ff  <= root_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      score_ff <= score_in;
   end

   assign arith_status.done  = (state_ff == A_DONE);
   assign arith_status.score = score_ff;

endmodule

FILE: design/windowed_good_bad_stability_score.sv
// top level: time-stamped measurement fifo, windowed sums and stability score
//
// Measurements arrive on req_chan as valid/ready words (good/bad flag, Q8.8
// value, 48-bit stamp). Each accepted word yields exactly one score word on
// rsp_chan carrying the Q1.15 score, both windowed sums and an overflow flag.
// csr_wr_en/csr_index/csr_wdata write the expiry enable (index 0) and the
// window length (index 1); write them only while the block is idle.
// One word at a time: req_chan.ready is high only while the sequencer idles.
// An accepted word is pushed into the fifo, whose 64-entry ram has a
// registered read; a full fifo first reads and evicts its oldest entry. With
// expiry on and the stamp at or above the window, head entries are read and
// popped while their stamp is at or below the new stamp minus the window,
// until the fifo runs dry. The bulk of the time is the shared subtractor: 23
// square root steps and 16 quotient steps, run only when the good sum exceeds
// the bad sum. The next word is taken only after the score word is loaded.
// A finished score waits in the output register; a stalled receiver holds it
// there while the next word is accepted and processed, then the block waits.
// Synchronous reset empties the fifo, clears the sums, the expiry and window
// registers and any pending score word; ram contents are left as they are.
module windowed_good_bad_stability_score (
   input  logic                                 clock,
   input  logic                                 reset,
   wgbss_req_if.sink                            req_chan,
   wgbss_rsp_if.source                          rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [wgbss_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wgbss_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EVICT_RD = 4'd1;
   localparam logic [3:0] S_EVICT    = 4'd2;
   localparam logic [3:0] S_PUSH     = 4'd3;
   localparam logic [3:0] S_EXP_RD   = 4'd4;
   localparam logic [3:0] S_EXP_CHK  = 4'd5;
   localparam logic [3:0] S_CALC     = 4'd6;
   localparam logic [3:0] S_WAIT     = 4'd7;
   localparam logic [3:0] S_OUT      = 4'd8;

   logic [3:0]                            state_ff, state_in;
   logic [wgbss_pkg::PTR_BITS-1:0]        head_ff, head_in;
   logic [wgbss_pkg::PTR_BITS-1:0]        tail_ff, tail_in;
   logic [wgbss_pkg::COUNT_BITS-1:0]      count_ff, count_in;
   logic [wgbss_pkg::SUM_BITS-1:0]        good_sum_ff, good_sum_in;
   logic [wgbss_pkg::SUM_BITS-1:0]        bad_sum_ff, bad_sum_in;
   logic                                  expiry_ff, expiry_in;
   logic [wgbss_pkg::WINDOW_BITS-1:0]     window_ff, window_in;
   wgbss_pkg::entry_type                  cur_ff, cur_in;
   logic                                  ovf_ff, ovf_in;
   logic [wgbss_pkg::STAMP_BITS-1:0]      thresh_ff, thresh_in;
   logic [wgbss_pkg::SCORE_BITS-1:0]      score_ff, score_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [wgbss_pkg::SCORE_BITS-1:0]      rsp_score_ff, rsp_score_in;
   logic [wgbss_pkg::SUM_BITS-1:0]        rsp_good_ff, rsp_good_in;
   logic [wgbss_pkg::SUM_BITS-1:0]        rsp_bad_ff, rsp_bad_in;
   logic                                  rsp_ovf_ff, rsp_ovf_in;

   wgbss_pkg::entry_type                  rd_entry;
   wgbss_pkg::arith_req_type              arith_req;
   wgbss_pkg::arith_status_type           arith_status;

   logic                                  accept;
   logic                                  expire;
   logic                                  pop;
   logic                                  rsp_load;
   logic [wgbss_pkg::PTR_BITS-1:0]        head_next;
   logic [wgbss_pkg::PTR_BITS-1:0]        tail_next;
   logic [wgbss_pkg::STAMP_BITS:0]        age_diff;

   wgbss_ram #(
      .WIDTH (wgbss_pkg::ENTRY_BITS),
      .DEPTH (wgbss_pkg::DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_PUSH),
      .wr_addr (tail_ff),
      .wr_data (cur_ff),
      .rd_addr (head_ff),
      .rd_data (rd_entry)
   );

   assign arith_req.start = (state_ff == S_CALC);
   assign arith_req.good  = good_sum_ff;
   assign arith_req.bad   = bad_sum_ff;

   wgbss_arith u_arith (
      .clock        (clock),
      .reset        (reset),
      .arith_req    (arith_req),
      .arith_status (arith_status)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && (state_ff == S_IDLE);

   assign head_next = (head_ff == wgbss_pkg::PTR_BITS'(wgbss_pkg::DEPTH - 1)) ? '0
                    : head_ff + 1'b1;
   assign tail_next = (tail_ff == wgbss_pkg::PTR_BITS'(wgbss_pkg::DEPTH - 1)) ? '0
                    : tail_ff + 1'b1;

   // borrow out means the stamp is still below the window: nothing expires
   assign age_diff = {1'b0, cur_ff.stamp}
                   - {{(wgbss_pkg::STAMP_BITS + 1 - wgbss_pkg::WINDOW_BITS){1'b0}}, window_ff};

   assign expire   = (rd_entry.stamp <= thresh_ff);
   assign pop      = (state_ff == S_EVICT) || ((state_ff == S_EXP_CHK) && expire);
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      good_sum_in = good_sum_ff;
      bad_sum_in  = bad_sum_ff;
      cur_in      = cur_ff;
      ovf_in      = ovf_ff;
      thresh_in   = thresh_ff;
      score_in    = score_ff;

      if (pop) begin
         head_in  = head_next;
         count_in = count_ff - 1'b1;
         if (rd_entry.is_bad) begin
            bad_sum_in = bad_sum_ff - wgbss_pkg::SUM_BITS'(rd_entry.value);
         end else begin
            good_sum_in = good_sum_ff - wgbss_pkg::SUM_BITS'(rd_entry.value);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_in.is_bad = req_chan.req_type;
               cur_in.value  = req_chan.measure_value[wgbss_pkg::VALUE_BITS-1:0];
               cur_in.stamp  = req_chan.stamp;
               ovf_in        = (count_ff == wgbss_pkg::COUNT_BITS'(wgbss_pkg::DEPTH));
               state_in      = ovf_in ? S_EVICT_RD : S_PUSH;
            end
         end
         S_EVICT_RD: begin
            state_in = S_EVICT;
         end
         S_EVICT: begin
            state_in = S_PUSH;
         end
         S_PUSH: begin
            tail_in   = tail_next;
            count_in  = count_ff + 1'b1;
            thresh_in = age_diff[wgbss_pkg::STAMP_BITS-1:0];
            if (cur_ff.is_bad) begin
               bad_sum_in = bad_sum_ff + wgbss_pkg::SUM_BITS'(cur_ff.value);
            end else begin
               good_sum_in = good_sum_ff + wgbss_pkg::SUM_BITS'(cur_ff.value);
            end
            state_in = (expiry_ff && !age_diff[wgbss_pkg::STAMP_BITS]) ? S_EXP_RD : S_CALC;
         end
         S_EXP_RD: begin
            state_in = (count_ff == '0) ? S_CALC : S_EXP_CHK;
         end
         S_EXP_CHK: begin
            state_in = expire ? S_EXP_RD : S_CALC;
         end
         S_CALC: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (arith_status.done) begin
               score_in = arith_status.score;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      expiry_in = expiry_ff;
      window_in = window_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            wgbss_pkg::CSR_EXPIRY_ENABLE: expiry_in = csr_wdata[0];
            wgbss_pkg::CSR_WINDOW_LENGTH: window_in = csr_wdata[wgbss_pkg::WINDOW_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // output register: holds the score word until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_score_in = rsp_score_ff;
      rsp_good_in  = rsp_good_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_score_in = score_ff;
         rsp_good_in  = good_sum_ff;
         rsp_bad_in   = bad_sum_ff;
         rsp_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         good_sum_ff  <= '0;
         bad_sum_ff   <= '0;
         expiry_ff    <= 1'b0;
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         good_sum_ff  <= good_sum_in;
         bad_sum_ff   <= bad_sum_in;
         expiry_ff    <= expiry_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      ovf_ff       <= ovf_in;
      thresh_ff    <= thresh_in;
      score_ff     <= score_in;
      rsp_score_ff <= rsp_score_in;
      rsp_good_ff  <= rsp_good_in;
      rsp_bad_ff   <= rsp_bad_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.score      = rsp_score_ff;
   assign rsp_chan.good_total = rsp_good_ff;
   assign rsp_chan.bad_total  = rsp_bad_ff;
   assign rsp_chan.overflowed = rsp_ovf_ff;

endmodule

FILE: design/wgbss_checker.sv
// port-level checks of the stability score block, bound to its top level
`include "windowed_good_bad_stability_score_defines.svh"

module wgbss_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [wgbss_pkg::SCORE_BITS-1:0] rsp_score,
   input logic [wgbss_pkg::SUM_BITS-1:0]   rsp_good_total,
   input logic [wgbss_pkg::SUM_BITS-1:0]   rsp_bad_total,
   input logic                             rsp_overflowed
);

   // one word at a time: the block is busy right after taking a word
   `WGBSS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")

   // a positive score needs more good than bad in the window
   `WGBSS_ASSERT_SAME(a_score_needs_good, clock, reset, rsp_valid, (rsp_score == '0) || (rsp_good_total > rsp_bad_total), "score without good majority")

   `WGBSS_ASSERT_SAME(a_score_in_range, clock, reset, rsp_valid, rsp_score <= wgbss_pkg::ONE_Q15, "score above one")

   `WGBSS_ASSERT_NEXT(a_reset_drops_rsp, clock, 1'b0, reset, !rsp_valid, "score word survives reset")

   `WGBSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_score) && $stable(rsp_good_total) && $stable(rsp_bad_total) && $stable(rsp_overflowed), "stalled word changed")

endmodule

bind windowed_good_bad_stability_score wgbss_checker u_wgbss_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_score      (rsp_chan.score),
   .rsp_good_total (rsp_chan.good_total),
   .rsp_bad_total  (rsp_chan.bad_total),
   .rsp_overflowed (rsp_chan.overflowed)
);
